>>> design/mas_pkg.sv
// Shared types and constants for the matrix add/subtract/multiply core.
// No dependencies; used by mas_mac and the top level (mas_ram does not use it).
`timescale 1ns / 1ps

package mas_pkg;

    localparam int ELEMENT_WIDTH   = 32;  // element and result width, fixed by the ports
    localparam int MAX_DIM_DEFAULT = 8;
    localparam int DIM_W           = 4;   // width of a dimension register
    localparam int IDX_FIELD_W     = 3;   // width of row/column fields
    localparam int CFG_INDEX_W     = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_A    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS_A    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_B    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS_B    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPERATION = 3'd4;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // request action codes
    localparam logic [1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // control from the sequencer to the arithmetic unit
    typedef struct packed {
        logic       valid;  // operands on the RAM outputs are live
        logic       clear;  // zero the accumulator
        logic [1:0] op;
    } t_mac_ctrl;

endpackage

>>> design/mas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mas_mac.sv
// Shared arithmetic unit: add, subtract or multiply stage, then accumulator.
// Depends on mas_pkg.
`timescale 1ns / 1ps

module mas_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mas_pkg::t_mac_ctrl                i_ctrl,
    input  logic [mas_pkg::ELEMENT_WIDTH-1:0] i_a,
    input  logic [mas_pkg::ELEMENT_WIDTH-1:0] i_b,
    output logic                              o_busy,
    output logic [mas_pkg::ELEMENT_WIDTH-1:0] o_acc
);

    logic                              r_stage_valid;
    logic [mas_pkg::ELEMENT_WIDTH-1:0] r_stage;
    logic [mas_pkg::ELEMENT_WIDTH-1:0] n_stage;
    logic [mas_pkg::ELEMENT_WIDTH-1:0] r_acc;

    always_comb begin
        case (i_ctrl.op)
            mas_pkg::OP_MUL: n_stage = i_a * i_b;   // low bits only, wraps
            mas_pkg::OP_SUB: n_stage = i_a - i_b;
            default:         n_stage = i_a + i_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else begin
            r_stage_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_stage_valid) begin
            r_acc <= r_acc + r_stage;
        end
    end

    assign o_busy = r_stage_valid;
    assign o_acc  = r_acc;

endmodule

>>> design/matrix_add_sub_multiply_core.sv
// Top level of the matrix add/subtract/multiply core: config registers,
// element stores, sequencer and output register. Depends on mas_pkg,
// mas_ram and mas_mac.
`timescale 1ns / 1ps

// Usage
//   Config: write rows_a, cols_a, rows_b, cols_b and operation through
//   i_cfg_we / i_cfg_index / i_cfg_data while the core is idle.
//   Input channel (i_in_valid / o_in_ready): a load-A or load-B request
//   stores one element; loads outside MAX_DIM are dropped.
//   A compute request emits the result matrix in row-major order on the
//   output channel (o_out_valid / i_out_ready), o_last_flag on the final
//   element. Bad dimensions or an unknown operation give one result with
//   o_status set, value and indexes zero, o_last_flag set.
//   Each result element takes K reads, K = cols_a for the product and 1 for
//   add/subtract, through the one shared multiply/add unit, then the RAM read
//   and arithmetic stages drain before the next element starts. o_in_ready is
//   low for the whole run.
//   An error result passes through the error state into the output register.
//   A stalled receiver holds the output register; the sequencer waits on it
//   and nothing is lost. The final result may still wait while new requests
//   are accepted.
//   Reset: registers return to 1,1,1,1,add; stores keep their contents and
//   are undefined until written.
module matrix_add_sub_multiply_core #(
    parameter int MAX_DIM = mas_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [mas_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mas_pkg::DIM_W-1:0]           i_cfg_data,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_action,
    input  logic [mas_pkg::IDX_FIELD_W-1:0]     i_row_index,
    input  logic [mas_pkg::IDX_FIELD_W-1:0]     i_col_index,
    input  logic signed [mas_pkg::ELEMENT_WIDTH-1:0] i_element_value,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mas_pkg::ELEMENT_WIDTH-1:0] o_result_value,
    output logic [mas_pkg::IDX_FIELD_W-1:0]     o_result_row,
    output logic [mas_pkg::IDX_FIELD_W-1:0]     o_result_col,
    output logic                                o_last_flag,
    output logic                                o_status
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int EW     = mas_pkg::ELEMENT_WIDTH;
    localparam int DW     = mas_pkg::DIM_W;
    localparam logic [DW-1:0] MAX_DIM_V = DW'(MAX_DIM);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ERR   = 4'b0010,
        S_RUN   = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    // ---------------- configuration registers ----------------
    logic [DW-1:0] r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [1:0]    r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= DW'(1);
            r_cols_a <= DW'(1);
            r_rows_b <= DW'(1);
            r_cols_b <= DW'(1);
            r_op     <= mas_pkg::OP_ADD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mas_pkg::CFG_ROWS_A:    r_rows_a <= i_cfg_data;
                mas_pkg::CFG_COLS_A:    r_cols_a <= i_cfg_data;
                mas_pkg::CFG_ROWS_B:    r_rows_b <= i_cfg_data;
                mas_pkg::CFG_COLS_B:    r_cols_b <= i_cfg_data;
                mas_pkg::CFG_OPERATION: r_op     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ---------------- dimension check ----------------
    logic is_mul, dims_ok;
    logic ra_ok, ca_ok, cb_ok;

    assign is_mul = (r_op == mas_pkg::OP_MUL);
    assign ra_ok  = (r_rows_a != '0) && (r_rows_a <= MAX_DIM_V);
    assign ca_ok  = (r_cols_a != '0) && (r_cols_a <= MAX_DIM_V);
    assign cb_ok  = (r_cols_b != '0) && (r_cols_b <= MAX_DIM_V);

    always_comb begin
        case (r_op)
            mas_pkg::OP_ADD,
            mas_pkg::OP_SUB: dims_ok = ra_ok && ca_ok && (r_rows_a == r_rows_b)
                                       && (r_cols_a == r_cols_b);
            mas_pkg::OP_MUL: dims_ok = ra_ok && ca_ok && cb_ok
                                       && (r_cols_a == r_rows_b);
            default:         dims_ok = 1'b0;
        endcase
    end

    // inner count and result width
    logic [DW-1:0] k_count, n_cols;
    assign k_count = is_mul ? r_cols_a : DW'(1);
    assign n_cols  = is_mul ? r_cols_b : r_cols_a;

    // ---------------- sequencer ----------------
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, r_j, r_k, n_i, n_j, n_k;
    logic             r_rd_valid;     // RAM read data is live
    logic             mac_busy;
    logic [EW-1:0]    mac_acc;
    logic             issue, mac_clear, load_res, load_err;
    logic             last_i, last_j, last_k;
    logic             out_free, in_accept;
    logic             r_out_valid;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_i    = (DW'(r_i) == r_rows_a - DW'(1));
    assign last_j    = (DW'(r_j) == n_cols - DW'(1));
    assign last_k    = (DW'(r_k) == k_count - DW'(1));

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        issue     = 1'b0;
        mac_clear = 1'b0;
        load_res  = 1'b0;
        load_err  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_action == mas_pkg::ACT_COMPUTE)) begin
                    if (dims_ok) begin
                        n_state   = S_RUN;
                        n_i       = '0;
                        n_j       = '0;
                        n_k       = '0;
                        mac_clear = 1'b1;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    load_err = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RUN: begin
                issue = 1'b1;
                if (last_k) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                // wait for the read and arithmetic stages to empty and the output register to be free
                if (!r_rd_valid && !mac_busy && out_free) begin
                    load_res  = 1'b1;
                    mac_clear = 1'b1;
                    if (last_i && last_j) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RUN;
                        if (last_j) begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_valid <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= issue;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // ---------------- element stores ----------------
    logic              in_range, we_a, we_b;
    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    logic [EW-1:0]     rdata_a, rdata_b;

    assign in_range = (DW'(i_row_index) < MAX_DIM_V) && (DW'(i_col_index) < MAX_DIM_V);
    assign waddr    = {i_row_index[IDX_W-1:0], i_col_index[IDX_W-1:0]};
    assign we_a     = in_accept && in_range && (i_action == mas_pkg::ACT_LOAD_A);
    assign we_b     = in_accept && in_range && (i_action == mas_pkg::ACT_LOAD_B);
    // product walks A along a row and B down a column; add/sub read matching cells
    assign raddr_a  = is_mul ? {r_i, r_k} : {r_i, r_j};
    assign raddr_b  = is_mul ? {r_k, r_j} : {r_i, r_j};

    mas_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_element_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mas_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_element_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // ---------------- shared arithmetic unit ----------------
    mas_pkg::t_mac_ctrl mac_ctrl;

    assign mac_ctrl.valid = r_rd_valid;
    assign mac_ctrl.clear = mac_clear;
    assign mac_ctrl.op    = r_op;

    mas_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    // ---------------- output register ----------------
    logic [EW-1:0]               r_out_value;
    logic [IDX_W-1:0]            r_out_row, r_out_col;
    logic                        r_out_last, r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_res || load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_err) begin
            r_out_value  <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= 1'b1;
        end else if (load_res) begin
            r_out_value  <= mac_acc;
            r_out_row    <= r_i;
            r_out_col    <= r_j;
            r_out_last   <= last_i && last_j;
            r_out_status <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_row   = mas_pkg::IDX_FIELD_W'(r_out_row);
    assign o_result_col   = mas_pkg::IDX_FIELD_W'(r_out_col);
    assign o_last_flag    = r_out_last;
    assign o_status       = r_out_status;

    // ---------------- assertions ----------------
    // no reads or arithmetic in flight once back at idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_valid && !mac_busy))
        else $error("pipeline busy while idle");

    // a held result is never overwritten by the sequencer
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_out_value) && $stable(r_out_row)
                                          && $stable(r_out_col)))
        else $error("pending result overwritten");

    // a compute request always leaves idle
    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_action == mas_pkg::ACT_COMPUTE)) |=> (r_state != S_IDLE))
        else $error("compute request dropped");

    // results are only loaded after the accumulator has settled
    a_load_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_res |-> ($past(r_state) == S_DRAIN || $past(r_state) == S_RUN)
                     && !r_rd_valid && !mac_busy)
        else $error("result taken before accumulation finished");

endmodule
